// File: src/adaptive_coefficient_update_defines.svh
// ----------------------------------------------------------------------------
// adaptive_coefficient_update_defines
// Assertion macros shared by the adaptive coefficient update block.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_COEFFICIENT_UPDATE_DEFINES_SVH
`define ADAPTIVE_COEFFICIENT_UPDATE_DEFINES_SVH

// condition must hold at every edge out of reset
`define ACU_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next, checked through reset too
`define ACU_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// File: src/acu_pkg.sv
// ----------------------------------------------------------------------------
// acu_pkg
// Types and constants of the adaptive coefficient update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acu_pkg;

  localparam int DW            = 32;     // Q16.16 data
  localparam int IW            = 8;      // coefficient index
  localparam int LRW           = 17;     // learning rate, Q1.16
  localparam int NUMW          = 49;     // a * m, signed
  localparam int QW            = 48;     // quotient bits
  localparam int NUM_COEFS_DEF = 256;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCW           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LRW-1:0] ONE_Q16  = 17'd65536;
  localparam logic [LRW-1:0] LR_RESET = 17'd3277;

  // one update handed from the state side to the divide side
  typedef struct packed {
    logic [IW-1:0]          idx;
    logic                   in_range;
    logic signed [DW-1:0]   coef;
    logic signed [NUMW-1:0] num;
    logic [DW-1:0]          msd;
  } job_t;

  typedef struct packed {
    logic           clearing;
    logic           hazard;
  } front_stat_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           pop;
  } q_stat_t;

endpackage

`default_nettype wire

// File: src/acu_ram.sv
// ----------------------------------------------------------------------------
// acu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: src/acu_front.sv
// ----------------------------------------------------------------------------
// acu_front
// Accepts transactions, reads and updates the per-slot averages, clears the
// state after reset and hands each update to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acu_front #(
  parameter int NUM_COEFS = acu_pkg::NUM_COEFS_DEF,
  localparam int AW       = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [acu_pkg::IW-1:0]       in_coef_index,
  input  wire logic signed [acu_pkg::DW-1:0] in_gradient_value,
  input  wire logic signed [acu_pkg::DW-1:0] in_coef_value,
  input  wire logic [acu_pkg::LRW-1:0]      alpha,
  output logic                              push,
  output acu_pkg::job_t                     push_job,
  output acu_pkg::front_stat_t              stat
);

  localparam int NS = 6;

  logic [acu_pkg::LRW-1:0] oma;
  logic                    accept;
  logic                    in_range_in;
  logic                    hazard;

  // per-stage control, stage 1 .. NS
  logic                    vld_r [1:NS];
  logic                    inr_r [1:NS];
  logic [acu_pkg::IW-1:0]  idx_r [1:NS];
  logic signed [acu_pkg::DW-1:0] c_r [1:NS];

  logic clearing_r;
  logic [AW-1:0] clr_cnt_r;

  logic [acu_pkg::DW-1:0] mg_rd, msd_rd;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [acu_pkg::DW-1:0] mg_wdata, msd_wdata;
  logic [AW-1:0]          addr6_r;

  // stage 1 payload
  logic signed [acu_pkg::DW-1:0] g1_r;
  // stage 2
  logic signed [49:0] p1_r, p2_r;
  logic signed [acu_pkg::DW-1:0] g2_r;
  logic [acu_pkg::DW-1:0] msd2_r;
  logic signed [49:0] p1_c, p2_c, sum_m;
  logic signed [acu_pkg::DW-1:0] m_c;
  logic signed [32:0] d_c;
  logic [32:0] ad_c;
  // stage 3
  logic signed [acu_pkg::DW-1:0] m3_r;
  logic [23:0] ad3_r;
  logic big3_r;
  logic [acu_pkg::DW-1:0] msd3_r;
  logic signed [49:0] num_c;
  // stage 4
  logic [47:0] sqp4_r;
  logic big4_r;
  logic signed [acu_pkg::NUMW-1:0] num4_r;
  logic signed [acu_pkg::DW-1:0] m4_r;
  logic [acu_pkg::DW-1:0] msd4_r;
  logic [48:0] sq_sum;
  // stage 5
  logic [acu_pkg::DW-1:0] sq5_r, msd5_r;
  logic signed [acu_pkg::NUMW-1:0] num5_r;
  logic signed [acu_pkg::DW-1:0] m5_r;
  // stage 6
  logic [48:0] p3_r, p4_r;
  logic signed [acu_pkg::NUMW-1:0] num6_r;
  logic signed [acu_pkg::DW-1:0] m6_r;
  logic [49:0] v_sum;
  logic [acu_pkg::DW-1:0] v_c;

  assign oma         = acu_pkg::ONE_Q16 - alpha;
  assign in_range_in = 32'(in_coef_index) < NUM_COEFS;

  // same slot still in flight: its averages are not yet written back
  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= NS; s++) begin
      if (vld_r[s] && inr_r[s] && idx_r[s] == in_coef_index && in_range_in) begin
        hazard = 1'b1;
      end
    end
  end

  assign busy   = clearing_r | hazard;
  assign accept = start & ~busy;
  assign stat   = '{clearing: clearing_r, hazard: hazard};

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[1] <= accept;
      for (int s = 2; s <= NS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    inr_r[1] <= in_range_in;
    idx_r[1] <= in_coef_index;
    c_r[1]   <= in_coef_value;
    for (int s = 2; s <= NS; s++) begin
      inr_r[s] <= inr_r[s-1];
      idx_r[s] <= idx_r[s-1];
      c_r[s]   <= c_r[s-1];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(NUM_COEFS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing_r | (vld_r[NS] & inr_r[NS]);
  assign ram_waddr = clearing_r ? clr_cnt_r : addr6_r;
  assign mg_wdata  = clearing_r ? '0 : m6_r;
  assign msd_wdata = clearing_r ? 32'(acu_pkg::ONE_Q16) : v_c;

  acu_ram #(.WIDTH(acu_pkg::DW), .DEPTH(NUM_COEFS)) u_mg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mg_wdata),
    .raddr (AW'(in_coef_index)),
    .rdata (mg_rd)
  );

  acu_ram #(.WIDTH(acu_pkg::DW), .DEPTH(NUM_COEFS)) u_msd_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (msd_wdata),
    .raddr (AW'(in_coef_index)),
    .rdata (msd_rd)
  );

  // stage 1: blend products for the gradient average
  assign p1_c = $signed({1'b0, oma}) * $signed(mg_rd);
  assign p2_c = $signed({1'b0, alpha}) * g1_r;

  // stage 2: round, deviation
  assign sum_m = p1_r + p2_r + 50'sd32768;
  assign m_c   = sum_m[47:16];
  assign d_c   = $signed({g2_r[31], g2_r}) - $signed({m_c[31], m_c});
  assign ad_c  = d_c[32] ? (33'd0 - 33'(d_c)) : 33'(d_c);

  // stage 3: square and step numerator
  assign num_c = $signed({1'b0, alpha}) * m3_r;

  // stage 4: round the square; anything at or above 2^24 clips
  assign sq_sum = {1'b0, sqp4_r} + 49'd32768;

  // stage 6: deviation average
  assign v_sum = {1'b0, p3_r} + {1'b0, p4_r} + 50'd32768;
  assign v_c   = (|v_sum[49:48]) ? '1 : v_sum[47:16];

  always_ff @(posedge clk) begin
    g1_r    <= in_gradient_value;

    p1_r    <= p1_c;
    p2_r    <= p2_c;
    g2_r    <= g1_r;
    msd2_r  <= msd_rd;

    m3_r    <= m_c;
    ad3_r   <= ad_c[23:0];
    big3_r  <= |ad_c[32:24];
    msd3_r  <= msd2_r;

    sqp4_r  <= ad3_r * ad3_r;
    big4_r  <= big3_r;
    num4_r  <= num_c[acu_pkg::NUMW-1:0];
    m4_r    <= m3_r;
    msd4_r  <= msd3_r;

    sq5_r   <= big4_r ? '1 : sq_sum[47:16];
    msd5_r  <= msd4_r;
    num5_r  <= num4_r;
    m5_r    <= m4_r;

    p3_r    <= 49'(oma) * 49'(msd5_r);
    p4_r    <= 49'(alpha) * 49'(sq5_r);
    num6_r  <= num5_r;
    m6_r    <= m5_r;
    addr6_r <= AW'(idx_r[5]);
  end

  assign push              = vld_r[NS];
  assign push_job.idx      = idx_r[NS];
  assign push_job.in_range = inr_r[NS];
  assign push_job.coef     = c_r[NS];
  assign push_job.num      = num6_r;
  assign push_job.msd      = v_c;

endmodule

`default_nettype wire

// File: src/acu_queue.sv
// ----------------------------------------------------------------------------
// acu_queue
// Short FIFO between the state update side and the divide side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  acu_pkg::job_t      push_job,
  output logic               pop_valid,
  output acu_pkg::job_t      pop_job,
  output acu_pkg::q_stat_t   stat
);

  localparam int D  = acu_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;

  acu_pkg::job_t              mem_r [D];
  logic [PW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [acu_pkg::QCW-1:0]    count_r;
  logic                       pop;

  // the divide side never stalls: drain whenever something is held
  assign pop       = count_r != '0;
  assign pop_valid = pop;
  assign pop_job   = mem_r[rd_ptr_r];
  assign stat      = '{count: count_r, pop: pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: src/acu_back.sv
// ----------------------------------------------------------------------------
// acu_back
// Pipelined restoring divider for the step, then step and result clipping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acu_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_valid,
  input  acu_pkg::job_t                      job,
  output logic                               out_strobe,
  output logic [acu_pkg::IW-1:0]             out_result_index,
  output logic signed [acu_pkg::DW-1:0]      out_new_coef,
  output logic                               out_saturated
);

  localparam int QW = acu_pkg::QW;
  localparam int DW = acu_pkg::DW;

  // stage 0 is the operand setup register, stage QW holds the quotient
  logic                   vld_r  [0:QW];
  logic [DW-1:0]          rem_r  [0:QW];
  logic [QW-1:0]          nq_r   [0:QW];
  logic [DW-1:0]          dv_r   [0:QW];
  logic                   sgn_r  [0:QW];
  logic                   inr_r  [0:QW];
  logic [acu_pkg::IW-1:0] idx_r  [0:QW];
  logic signed [DW-1:0]   c_r    [0:QW];

  logic [acu_pkg::NUMW-1:0] an_full;
  logic [DW-1:0]            div_c;
  logic [QW-1:0]            dividend_c;

  // magnitude of a*m plus half the divisor gives round-half-away
  assign an_full    = job.num[acu_pkg::NUMW-1] ? (acu_pkg::NUMW'(0) - job.num) : job.num;
  assign div_c      = (job.msd == '0) ? DW'(1) : job.msd;
  assign dividend_c = an_full[QW-1:0] + QW'(div_c >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= job_valid;
      for (int k = 1; k <= QW; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= dividend_c;
    dv_r[0]  <= div_c;
    sgn_r[0] <= job.num[acu_pkg::NUMW-1];
    inr_r[0] <= job.in_range;
    idx_r[0] <= job.idx;
    c_r[0]   <= job.coef;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0]   trial;
    logic          take;
    assign trial = {rem_r[k], nq_r[k][QW-1]};
    assign take  = trial >= {1'b0, dv_r[k]};

    always_ff @(posedge clk) begin
      rem_r[k+1] <= take ? DW'(trial - {1'b0, dv_r[k]}) : trial[DW-1:0];
      nq_r[k+1]  <= {nq_r[k][QW-2:0], take};
      dv_r[k+1]  <= dv_r[k];
      sgn_r[k+1] <= sgn_r[k];
      inr_r[k+1] <= inr_r[k];
      idx_r[k+1] <= idx_r[k];
      c_r[k+1]   <= c_r[k];
    end
  end

  // step clip
  logic [QW-1:0]        q;
  logic                 pos_ovf, neg_ovf;
  logic signed [DW-1:0] step_nxt;
  logic                 sat_nxt;
  logic signed [DW-1:0] step_r;
  logic                 sat_r, vp_r;
  logic [acu_pkg::IW-1:0] idxp_r;
  logic signed [DW-1:0] cp_r;

  assign q       = nq_r[QW];
  assign pos_ovf = !sgn_r[QW] && (|q[QW-1:DW-1]);
  assign neg_ovf = sgn_r[QW] && (q > QW'(33'h080000000));

  always_comb begin
    if (!inr_r[QW]) begin
      step_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (pos_ovf) begin
      step_nxt = {1'b0, {(DW-1){1'b1}}};
      sat_nxt  = 1'b1;
    end else if (neg_ovf) begin
      step_nxt = {1'b1, {(DW-1){1'b0}}};
      sat_nxt  = 1'b1;
    end else begin
      step_nxt = sgn_r[QW] ? $signed(DW'(0) - q[DW-1:0]) : $signed(q[DW-1:0]);
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    sat_r  <= sat_nxt;
    idxp_r <= idx_r[QW];
    cp_r   <= c_r[QW];
  end

  // result clip
  logic signed [DW:0] diff;
  logic               rovf;
  assign diff = $signed({cp_r[DW-1], cp_r}) - $signed({step_r[DW-1], step_r});
  assign rovf = diff[DW] != diff[DW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    out_result_index <= idxp_r;
    out_saturated    <= sat_r | rovf;
    if (!rovf) begin
      out_new_coef <= diff[DW-1:0];
    end else if (diff[DW]) begin
      out_new_coef <= {1'b1, {(DW-1){1'b0}}};
    end else begin
      out_new_coef <= {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// File: src/adaptive_coefficient_update.sv
// ----------------------------------------------------------------------------
// adaptive_coefficient_update
// Per-coefficient adaptive gradient step with running averages per slot.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears for one cycle with out_strobe, and the receiver cannot stall.
// Transactions to distinct slots go in one per cycle. A slot's averages go
// through a six-stage read-blend-write loop in the front part, so a
// transaction to a slot that is still in that loop holds busy high until the
// write-back lands. After reset a clearing pass over all NUM_COEFS slots
// initializes the averages with busy high; learning rate writes are taken
// during it.
`timescale 1ns / 1ps
`default_nettype none

`include "adaptive_coefficient_update_defines.svh"

module adaptive_coefficient_update #(
  parameter int NUM_COEFS = acu_pkg::NUM_COEFS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [acu_pkg::IW-1:0]         in_coef_index,
  input  wire logic signed [acu_pkg::DW-1:0]  in_gradient_value,
  input  wire logic signed [acu_pkg::DW-1:0]  in_coef_value,
  input  wire logic                           cfg_we,
  input  wire logic [acu_pkg::LRW-1:0]        cfg_wdata,
  output logic                                out_strobe,
  output logic [acu_pkg::IW-1:0]              out_result_index,
  output logic signed [acu_pkg::DW-1:0]       out_new_coef,
  output logic                                out_saturated
);

  logic [acu_pkg::LRW-1:0] lr_r;
  logic [acu_pkg::LRW-1:0] alpha;

  logic                  q_push;
  acu_pkg::job_t         q_in_job;
  logic                  q_valid;
  acu_pkg::job_t         q_out_job;
  acu_pkg::front_stat_t  fstat;
  acu_pkg::q_stat_t      qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= acu_pkg::LR_RESET;
    end else if (cfg_we) begin
      lr_r <= cfg_wdata;
    end
  end

  // rates above 1.0 act as 1.0
  assign alpha = (lr_r > acu_pkg::ONE_Q16) ? acu_pkg::ONE_Q16 : lr_r;

  acu_front #(.NUM_COEFS(NUM_COEFS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_coef_index     (in_coef_index),
    .in_gradient_value (in_gradient_value),
    .in_coef_value     (in_coef_value),
    .alpha             (alpha),
    .push              (q_push),
    .push_job          (q_in_job),
    .stat              (fstat)
  );

  acu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .pop_valid (q_valid),
    .pop_job   (q_out_job),
    .stat      (qstat)
  );

  acu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (q_out_job),
    .out_strobe       (out_strobe),
    .out_result_index (out_result_index),
    .out_new_coef     (out_new_coef),
    .out_saturated    (out_saturated)
  );

  `ACU_CHECK_NEXT(a_reset_busy, !rst_n, busy, "busy low right after reset")
  `ACU_CHECK(a_no_push_clear, !(fstat.clearing && q_push), "queue push during clearing")
  `ACU_CHECK(a_queue_bound, qstat.count <= acu_pkg::QCW'(acu_pkg::QUEUE_DEPTH), "queue overflow")
  `ACU_CHECK(a_queue_drain, !(qstat.count > acu_pkg::QCW'(1)), "queue backs up")

endmodule

`default_nettype wire

// File: tb/adaptive_coefficient_update_tb.sv
// ----------------------------------------------------------------------------
// adaptive_coefficient_update_tb
// Self-checking bench for the adaptive coefficient step. Slot averages and the
// learning rate are modeled in a scoreboard that predicts every result in
// order. Directed extremes come first, then random traffic over several rates,
// with random gaps and repeated slots to hit the write-back hazard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_coefficient_update_tb;

  typedef struct {
    logic [acu_pkg::IW-1:0]        idx;
    logic signed [acu_pkg::DW-1:0] coef;
    logic                          sat;
  } coef_result_t;

  class coef_scoreboard;
    int unsigned          rate;
    int                   mean_grad [256];
    logic [31:0]          mean_sq_dev [256];
    coef_result_t         pending_q[$];
    int                   errors;
    int                   checked;
    int                   sat_seen;

    function new();
      rate = 32'(acu_pkg::LR_RESET);
      errors = 0;
      checked = 0;
      sat_seen = 0;
      for (int i = 0; i < 256; i++) begin
        mean_grad[i] = 0;
        mean_sq_dev[i] = 32'd65536;
      end
    endfunction

    function void set_rate(int unsigned r);
      rate = r & 32'h1FFFF;
    endfunction

    // one accepted transaction: update the slot and queue its result
    function void note(logic [acu_pkg::IW-1:0] idx, logic signed [acu_pkg::DW-1:0] g,
                       logic signed [acu_pkg::DW-1:0] c);
      longint       a, m, gg, cc, d, num, step, res;
      logic [63:0]  ua, ad, sq, v, anum, q;
      coef_result_t r;
      a = (rate > 65536) ? 65536 : rate;
      ua = a;
      gg = g;
      cc = c;
      r.sat = 1'b0;
      m = ((65536 - a) * longint'(mean_grad[idx]) + a * gg + 32768) >>> 16;
      d = gg - m;
      ad = (d < 0) ? -d : d;
      sq = (ad * ad + 64'd32768) >> 16;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      v = ((64'd65536 - ua) * {32'd0, mean_sq_dev[idx]} + ua * sq + 64'd32768) >> 16;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      mean_grad[idx] = int'(m);
      mean_sq_dev[idx] = v[31:0];
      if (v == 0) v = 1;
      num = a * m;
      anum = (num < 0) ? -num : num;
      q = (anum + v / 2) / v;
      step = (num < 0) ? -longint'(q) : longint'(q);
      if (step > 64'sd2147483647) begin
        step = 64'sd2147483647; r.sat = 1'b1;
      end else if (step < -64'sd2147483648) begin
        step = -64'sd2147483648; r.sat = 1'b1;
      end
      res = cc - step;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647; r.sat = 1'b1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648; r.sat = 1'b1;
      end
      r.idx = idx;
      r.coef = res[31:0];
      pending_q.push_back(r);
    endfunction

    function void check(logic [acu_pkg::IW-1:0] idx, logic signed [acu_pkg::DW-1:0] coef,
                        logic sat);
      coef_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d coef=%0d sat=%0b", $time, idx, coef, sat);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (sat) sat_seen++;
      if (idx !== e.idx) begin
        $display("%0t: result_index expected %0d actual %0d", $time, e.idx, idx);
        errors++;
      end
      if (coef !== e.coef) begin
        $display("%0t: new_coef expected %0d actual %0d (idx %0d)", $time, e.coef, coef, e.idx);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b (idx %0d)", $time, e.sat, sat, e.idx);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [acu_pkg::IW-1:0]        in_coef_index;
  logic signed [acu_pkg::DW-1:0] in_gradient_value;
  logic signed [acu_pkg::DW-1:0] in_coef_value;
  logic                          cfg_we;
  logic [acu_pkg::LRW-1:0]       cfg_wdata;
  logic                          out_strobe;
  logic [acu_pkg::IW-1:0]        out_result_index;
  logic signed [acu_pkg::DW-1:0] out_new_coef;
  logic                          out_saturated;

  coef_scoreboard sb = new();

  adaptive_coefficient_update i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_coef_index     (in_coef_index),
    .in_gradient_value (in_gradient_value),
    .in_coef_value     (in_coef_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_result_index  (out_result_index),
    .out_new_coef      (out_new_coef),
    .out_saturated     (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transactions and results are sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note(in_coef_index, in_gradient_value, in_coef_value);
      if (out_strobe) sb.check(out_result_index, out_new_coef, out_saturated);
    end
  end

  task automatic send_update(logic [acu_pkg::IW-1:0] idx, logic [acu_pkg::DW-1:0] g,
                             logic [acu_pkg::DW-1:0] c);
    start             <= 1'b1;
    in_coef_index     <= idx;
    in_gradient_value <= g;
    in_coef_value     <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) idle_cycles(0);
    else if (p < 95) idle_cycles($urandom_range(3, 1));
    else idle_cycles($urandom_range(70, 10));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(logic [acu_pkg::LRW-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_rate(32'(r));
  endtask

  task automatic random_burst(int n);
    logic [acu_pkg::IW-1:0] idx;
    logic [acu_pkg::DW-1:0] g, c;
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      // a few hot slots keep the averages deep and the hazard path busy
      if (p < 50) idx = acu_pkg::IW'($urandom_range(3));
      else idx = acu_pkg::IW'($urandom());
      p = $urandom_range(99);
      if (p < 70) g = $signed($urandom_range(262143)) - 131072;
      else g = $urandom();
      p = $urandom_range(99);
      if (p < 10) c = (p < 5) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else c = $urandom();
      send_update(idx, g, c);
      if ($urandom_range(99) < 30) random_gap();
    end
  endtask

  initial begin
    logic [acu_pkg::LRW-1:0] rates [8];
    rst_n = 1'b0;
    start = 1'b0;
    in_coef_index = '0;
    in_gradient_value = '0;
    in_coef_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset rate, field extremes, back-to-back same slot
    send_update(8'd0, 32'h0000_0000, 32'h0000_0000);
    send_update(8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_update(8'd255, 32'h8000_0000, 32'h8000_0000);
    send_update(8'd255, 32'h7FFF_FFFF, 32'h8000_0000);
    send_update(8'd1, 32'hFFFF_FFFF, 32'h0001_0000);
    send_update(8'd1, 32'h0001_0000, 32'hFFFF_0000);
    idle_cycles(2);
    send_update(8'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    drain_results();

    // alpha of one: zero deviation, divisor floor, clipped step and result
    write_rate(17'd65536);
    send_update(8'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_update(8'd3, 32'h8000_0000, 32'h7FFF_FFFF);
    send_update(8'd4, 32'h0000_0001, 32'h0000_0000);
    send_update(8'd4, 32'hFFFF_FFFF, 32'h8000_0000);
    send_update(8'd5, 32'h0000_0000, 32'h1234_5678);
    drain_results();

    // rate above one acts as one; zero rate leaves everything alone
    write_rate(17'h1FFFF);
    send_update(8'd2, 32'h8000_0000, 32'h7FFF_FFFF);
    send_update(8'd6, 32'h4000_0000, 32'h0000_0000);
    drain_results();
    write_rate(17'd0);
    send_update(8'd2, 32'h7FFF_FFFF, 32'h0000_0000);
    send_update(8'd7, 32'h8000_0000, 32'h8000_0000);
    drain_results();

    rates[0] = 17'd3277;
    rates[1] = 17'd1;
    rates[2] = 17'd65536;
    rates[3] = 17'd65537;
    rates[4] = 17'd0;
    rates[5] = 17'd32768;
    rates[6] = 17'h0FFFF;
    rates[7] = 17'd655;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) write_rate(rates[ph]);
      else write_rate(acu_pkg::LRW'($urandom_range(131071)));
      random_burst(100);
      drain_results();
    end

    repeat (70) @(posedge clk);
    $display("checked %0d results over 11 learning rates, %0d saturated",
             sb.checked, sb.sat_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("adaptive_coefficient_update_tb OK");
    end else begin
      $display("adaptive_coefficient_update_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout, %0d results still pending", sb.pending_q.size());
    $display("adaptive_coefficient_update_tb NOT OK");
    $finish;
  end

endmodule
